>>> hw/rtl/psxc_pkg.sv
// ----------------------------------------------------------------------------
// psxc_pkg
// Shared types, constants and helper functions of the packet swap-XOR cipher.
// ----------------------------------------------------------------------------
package psxc_pkg;

  // Packet geometry
  localparam int unsigned PacketBytes = 1024;
  localparam int unsigned AddrW       = $clog2(PacketBytes);
  localparam int unsigned CountW      = AddrW + 1;

  // Generator constants
  localparam logic [31:0] LcgMul = 32'h0003_43FD;
  localparam logic [31:0] LcgInc = 32'h0026_9EC3;

  // Generator draws and divisors
  localparam int unsigned DrawW    = 15;
  localparam int unsigned StackLen = 10;
  localparam int unsigned RuleCnt  = 21;
  localparam int unsigned RuleW    = 5;
  localparam int unsigned XorW     = 17;

  // Operation codes
  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_RUN  = 2'd1,
    OP_READ = 2'd2,
    OP_NOP  = 2'd3
  } op_e;

  // Input word
  typedef struct packed {
    logic [1:0]  opcode;
    logic [7:0]  data_byte;
    logic        encrypt_mode;
    logic [31:0] seed_word;
  } in_t;

  // Output word
  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last_byte;
    logic [10:0] packet_length;
    logic [31:0] seed_out;
    logic [15:0] checksum_value;
    logic        error_flag;
  } out_t;

  // Datapath commands
  typedef enum logic [4:0] {
    C_NONE,
    C_CAPTURE,
    C_LOAD,
    C_RD_ISSUE,
    C_RD_OUT,
    C_RUN_INIT,
    C_ERR_OUT,
    C_RUN_OUT,
    C_SUM,
    C_CK_LO,
    C_CK_HI,
    C_STK,
    C_XW_DRAW,
    C_XW_A,
    C_XW_B,
    C_XW_C,
    C_OFF_DRAW,
    C_OFF_W,
    C_RULE_W,
    C_XP_RD,
    C_XP_WR,
    C_SW_RD0,
    C_SW_RD1,
    C_SW_RD2,
    C_SW_WR0,
    C_SW_WR1,
    C_CS_RD0,
    C_CS_RD1,
    C_CS_RD2
  } cmd_e;

  // Datapath status toward the controller
  typedef struct packed {
    op_e  op;
    logic enc;
    logic run_err;
    logic stk_end;
    logic pos_end;
    logic swap_end;
    logic scan_done;
    logic mod_busy;
    logic out_free;
  } status_t;

  // Encrypt-side rule translation
  function automatic logic [RuleW-1:0] rule_map(input logic [RuleW-1:0] r);
    logic [RuleW-1:0] m;
    case (r)
      5'd0:  m = 5'd0;
      5'd1:  m = 5'd5;
      5'd2:  m = 5'd2;
      5'd3:  m = 5'd9;
      5'd4:  m = 5'd11;
      5'd5:  m = 5'd1;
      5'd6:  m = 5'd18;
      5'd7:  m = 5'd7;
      5'd8:  m = 5'd14;
      5'd9:  m = 5'd3;
      5'd10: m = 5'd10;
      5'd11: m = 5'd4;
      5'd12: m = 5'd12;
      5'd13: m = 5'd13;
      5'd14: m = 5'd8;
      5'd15: m = 5'd15;
      5'd16: m = 5'd19;
      5'd17: m = 5'd20;
      5'd18: m = 5'd6;
      5'd19: m = 5'd16;
      5'd20: m = 5'd17;
      default: m = r;
    endcase
    return m;
  endfunction

  // Nibble swap of a byte pair; returns {new byte at position, new byte at partner}
  function automatic logic [15:0] swap_pair(input logic [RuleW-1:0] rule,
                                            input logic [7:0] a, input logic [7:0] c);
    logic [3:0] ah, al, ch, cl;
    logic [7:0] e, p;
    ah = a[7:4];
    al = a[3:0];
    ch = c[7:4];
    cl = c[3:0];
    case (rule)
      5'd0:  begin e = {ch, al}; p = {ah, cl}; end
      5'd1:  begin e = {ch, al}; p = {cl, ah}; end
      5'd2:  begin e = {cl, ch}; p = {al, ah}; end
      5'd3:  begin e = {cl, ah}; p = {ch, al}; end
      5'd4:  begin e = {cl, al}; p = {ah, ch}; end
      5'd5:  begin e = {ch, ah}; p = {al, cl}; end
      5'd6:  begin e = {cl, ah}; p = {al, ch}; end
      5'd7:  begin e = {ch, ah}; p = {cl, al}; end
      5'd8:  begin e = {cl, al}; p = {ch, ah}; end
      5'd9:  begin e = {ah, ch}; p = {cl, al}; end
      5'd10: begin e = {al, cl}; p = {ah, ch}; end
      5'd11: begin e = {al, ch}; p = {ah, cl}; end
      5'd12: begin e = {al, ah}; p = {cl, ch}; end
      5'd13: begin e = a;        p = c;        end
      5'd14: begin e = {ah, ch}; p = {al, cl}; end
      5'd15: begin e = {ah, cl}; p = {ch, al}; end
      5'd16: begin e = a;        p = {cl, ch}; end
      5'd17: begin e = {al, cl}; p = {ch, ah}; end
      5'd18: begin e = {al, ch}; p = {cl, ah}; end
      5'd19: begin e = {al, ah}; p = c;        end
      5'd20: begin e = {ah, cl}; p = {al, ch}; end
      default: begin e = c; p = a; end
    endcase
    return {e, p};
  endfunction

endpackage

>>> hw/rtl/packet_swap_xor_cipher_top.sv
// ----------------------------------------------------------------------------
// packet_swap_xor_cipher_top
// Packet swap-XOR cipher: load bytes, run encrypt or decrypt, read bytes.
// ----------------------------------------------------------------------------
// Load writes one byte; read issues a memory read and then puts out its result word,
// one word at a time. A run over L bytes (checksum included) computes per position
// an XOR word, then partner and rule (waiting on the 15-step serial remainder by
// L), and runs an XOR pass and a swap pass; encrypt adds a checksum scan.
// Reset clears the byte count, read pointer and generator; memories need no clearing.
// ----------------------------------------------------------------------------
module packet_swap_xor_cipher_top (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  psxc_pkg::in_t   in_data_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output psxc_pkg::out_t  out_data_o
);

  psxc_pkg::cmd_e    cmd;
  psxc_pkg::status_t status;

  psxc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  psxc_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .status_o    (status)
  );

endmodule

>>> hw/rtl/psxc_mod.sv
// ----------------------------------------------------------------------------
// psxc_mod
// Serial remainder unit: one restoring step per cycle over a generator draw.
// ----------------------------------------------------------------------------
module psxc_mod (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [psxc_pkg::DrawW-1:0]        dividend_i,
  input  logic [psxc_pkg::CountW-1:0]       divisor_i,
  output logic                              busy_o,
  output logic [psxc_pkg::CountW-1:0]       rem_o
);

  localparam int unsigned StepW = $clog2(psxc_pkg::DrawW);

  logic                              busy_q;
  logic [StepW-1:0]                  cnt_q;
  logic [psxc_pkg::DrawW-1:0]        dv_q;
  logic [psxc_pkg::CountW-1:0]       dsr_q;
  logic [psxc_pkg::CountW-1:0]       rem_q;
  logic [psxc_pkg::CountW-1:0]       trial;

  // Shift in next dividend bit
  assign trial = {rem_q[psxc_pkg::CountW-2:0], dv_q[psxc_pkg::DrawW-1]};

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= StepW'(psxc_pkg::DrawW - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Restoring step
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dv_q  <= dividend_i;
      dsr_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dv_q  <= {dv_q[psxc_pkg::DrawW-2:0], 1'b0};
      rem_q <= (trial >= dsr_q) ? trial - dsr_q : trial;
    end
  end

  assign busy_o = busy_q;
  assign rem_o  = rem_q;

endmodule

>>> hw/rtl/psxc_ctrl.sv
// ----------------------------------------------------------------------------
// psxc_ctrl
// Sequencer of the cipher: walks load, read and the phases of a run.
// ----------------------------------------------------------------------------
module psxc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  psxc_pkg::status_t  status_i,
  output psxc_pkg::cmd_e     cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE, ST_DISP, ST_RD_OUT, ST_ERR_OUT, ST_RUN_OUT,
    ST_SUM, ST_CK_LO, ST_CK_HI, ST_STK,
    ST_XW0, ST_XW0W, ST_XW1, ST_XW1W, ST_XW2, ST_XW3,
    ST_OF0, ST_OF0W, ST_OF1, ST_OF1W, ST_OF2,
    ST_XP0, ST_XP1,
    ST_SW0, ST_SW1, ST_SW2, ST_SW3, ST_SW4,
    ST_CS0, ST_CS1, ST_CS2
  } state_e;

  state_e state_q, state_d;

  // Next state and command
  always_comb begin
    state_d = state_q;
    cmd_o   = psxc_pkg::C_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o   = psxc_pkg::C_CAPTURE;
          state_d = ST_DISP;
        end
      end
      ST_DISP: begin
        unique case (status_i.op)
          psxc_pkg::OP_LOAD: begin
            cmd_o   = psxc_pkg::C_LOAD;
            state_d = ST_IDLE;
          end
          psxc_pkg::OP_READ: begin
            cmd_o   = psxc_pkg::C_RD_ISSUE;
            state_d = ST_RD_OUT;
          end
          psxc_pkg::OP_RUN: begin
            cmd_o = psxc_pkg::C_RUN_INIT;
            if (status_i.run_err) state_d = ST_ERR_OUT;
            else if (status_i.enc) state_d = ST_SUM;
            else state_d = ST_STK;
          end
          default: state_d = ST_IDLE;
        endcase
      end
      ST_RD_OUT: begin
        if (status_i.out_free) begin
          cmd_o   = psxc_pkg::C_RD_OUT;
          state_d = ST_IDLE;
        end
      end
      ST_ERR_OUT: begin
        if (status_i.out_free) begin
          cmd_o   = psxc_pkg::C_ERR_OUT;
          state_d = ST_IDLE;
        end
      end
      ST_RUN_OUT: begin
        if (status_i.out_free) begin
          cmd_o   = psxc_pkg::C_RUN_OUT;
          state_d = ST_IDLE;
        end
      end
      ST_SUM: begin
        if (status_i.scan_done) state_d = ST_CK_LO;
        else cmd_o = psxc_pkg::C_SUM;
      end
      ST_CK_LO: begin
        cmd_o   = psxc_pkg::C_CK_LO;
        state_d = ST_CK_HI;
      end
      ST_CK_HI: begin
        cmd_o   = psxc_pkg::C_CK_HI;
        state_d = ST_STK;
      end
      ST_STK: begin
        cmd_o = psxc_pkg::C_STK;
        if (status_i.stk_end) state_d = ST_XW0;
      end
      ST_XW0: begin
        cmd_o   = psxc_pkg::C_XW_DRAW;
        state_d = ST_XW0W;
      end
      ST_XW0W: begin
        if (!status_i.mod_busy) state_d = ST_XW1;
      end
      ST_XW1: begin
        cmd_o   = psxc_pkg::C_XW_A;
        state_d = ST_XW1W;
      end
      ST_XW1W: begin
        if (!status_i.mod_busy) state_d = ST_XW2;
      end
      ST_XW2: begin
        cmd_o   = psxc_pkg::C_XW_B;
        state_d = ST_XW3;
      end
      ST_XW3: begin
        cmd_o   = psxc_pkg::C_XW_C;
        state_d = status_i.pos_end ? ST_OF0 : ST_XW0;
      end
      ST_OF0: begin
        cmd_o   = psxc_pkg::C_OFF_DRAW;
        state_d = ST_OF0W;
      end
      ST_OF0W: begin
        if (!status_i.mod_busy) state_d = ST_OF1;
      end
      ST_OF1: begin
        cmd_o   = psxc_pkg::C_OFF_W;
        state_d = ST_OF1W;
      end
      ST_OF1W: begin
        if (!status_i.mod_busy) state_d = ST_OF2;
      end
      ST_OF2: begin
        cmd_o = psxc_pkg::C_RULE_W;
        if (!status_i.pos_end) state_d = ST_OF0;
        else if (status_i.enc) state_d = ST_XP0;
        else state_d = ST_SW0;
      end
      ST_XP0: begin
        cmd_o   = psxc_pkg::C_XP_RD;
        state_d = ST_XP1;
      end
      ST_XP1: begin
        cmd_o = psxc_pkg::C_XP_WR;
        if (!status_i.pos_end) state_d = ST_XP0;
        else if (status_i.enc) state_d = ST_SW0;
        else state_d = ST_CS0;
      end
      ST_SW0: begin
        cmd_o   = psxc_pkg::C_SW_RD0;
        state_d = ST_SW1;
      end
      ST_SW1: begin
        cmd_o   = psxc_pkg::C_SW_RD1;
        state_d = ST_SW2;
      end
      ST_SW2: begin
        cmd_o   = psxc_pkg::C_SW_RD2;
        state_d = ST_SW3;
      end
      ST_SW3: begin
        cmd_o   = psxc_pkg::C_SW_WR0;
        state_d = ST_SW4;
      end
      ST_SW4: begin
        cmd_o = psxc_pkg::C_SW_WR1;
        if (!status_i.swap_end) state_d = ST_SW0;
        else if (status_i.enc) state_d = ST_RUN_OUT;
        else state_d = ST_XP0;
      end
      ST_CS0: begin
        cmd_o   = psxc_pkg::C_CS_RD0;
        state_d = ST_CS1;
      end
      ST_CS1: begin
        cmd_o   = psxc_pkg::C_CS_RD1;
        state_d = ST_CS2;
      end
      ST_CS2: begin
        cmd_o   = psxc_pkg::C_CS_RD2;
        state_d = ST_RUN_OUT;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

>>> hw/rtl/psxc_dp.sv
// ----------------------------------------------------------------------------
// psxc_dp
// Datapath of the cipher: packet and table memories, generator, counters,
// remainder unit and the output word register.
// ----------------------------------------------------------------------------
module psxc_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  psxc_pkg::cmd_e     cmd_i,
  input  psxc_pkg::in_t      in_data_i,
  input  logic               out_ready_i,
  output logic               out_valid_o,
  output psxc_pkg::out_t     out_data_o,
  output psxc_pkg::status_t  status_o
);

  localparam int unsigned AW = psxc_pkg::AddrW;
  localparam int unsigned CW = psxc_pkg::CountW;
  localparam int unsigned XW = psxc_pkg::XorW;
  localparam int unsigned RW = psxc_pkg::RuleW;
  localparam int unsigned SW = $clog2(psxc_pkg::StackLen);
  localparam logic [CW-1:0] Full = CW'(psxc_pkg::PacketBytes);

  // Reciprocals for the constant remainders of a 15-bit draw
  localparam logic [15:0] Rcp10 = 16'd52429;
  localparam logic [15:0] Rcp21 = 16'd49933;

  // Captured input word
  psxc_pkg::in_t in_q;

  // Control registers
  logic [CW-1:0] bc_q, rp_q, len_q, idx_q;
  logic [31:0]   gen_q, sout_q;
  logic [15:0]   sum_q;
  logic          rdv_q, out_valid_q;
  psxc_pkg::out_t out_q, out_d;
  logic          out_load;

  // Payload registers
  logic [7:0]    a_q, c_q, p_q;
  logic [15:0]   w_q;
  logic [XW-1:0] prev1_q, prev2_q;
  logic [7:0]    stk1_q [psxc_pkg::StackLen];
  logic [7:0]    stk2_q [psxc_pkg::StackLen];

  // Memories
  logic [7:0]    pkt_mem  [psxc_pkg::PacketBytes];
  logic [XW-1:0] xw_mem   [psxc_pkg::PacketBytes];
  logic [AW-1:0] off_mem  [psxc_pkg::PacketBytes];
  logic [RW-1:0] rule_mem [psxc_pkg::PacketBytes];
  logic [7:0]    pkt_rd_q;
  logic [XW-1:0] xw_rd_q;
  logic [AW-1:0] off_rd_q;
  logic [RW-1:0] rule_rd_q;

  logic          pkt_we, pkt_re;
  logic [AW-1:0] pkt_wa, pkt_ra;
  logic [7:0]    pkt_wd;

  // Generator and remainder unit
  logic [31:0]              gen_nxt;
  logic [psxc_pkg::DrawW-1:0] draw;
  logic                     mod_start, mod_busy;
  logic [CW-1:0]            mod_rem;

  // Constant remainders of the last draw
  logic [psxc_pkg::DrawW-1:0] draw_q;
  logic [11:0]              q10_q;
  logic [10:0]              q21_q;
  logic [30:0]              prod10, prod21;
  logic [14:0]              rem10, rem21;

  // Misc combinational
  logic [CW-1:0] rd_len, last_pos, off_val, run_len;
  logic          run_err, last;
  logic [7:0]    xp_byte;
  logic [RW-1:0] sw_rule;
  logic [15:0]   sw_res;
  logic          is_draw;

  assign gen_nxt = gen_q * psxc_pkg::LcgMul + psxc_pkg::LcgInc;
  assign draw    = gen_nxt[30:16];
  assign is_draw = (cmd_i == psxc_pkg::C_STK) || (cmd_i == psxc_pkg::C_XW_DRAW) ||
                   (cmd_i == psxc_pkg::C_XW_A) || (cmd_i == psxc_pkg::C_XW_C) ||
                   (cmd_i == psxc_pkg::C_OFF_DRAW) || (cmd_i == psxc_pkg::C_OFF_W);

  psxc_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (draw),
    .divisor_i  (len_q),
    .busy_o     (mod_busy),
    .rem_o      (mod_rem)
  );

  // Start the serial remainder only for the partner offset draw
  assign mod_start = (cmd_i == psxc_pkg::C_OFF_DRAW);

  // Quotients by ten and by 21 from a reciprocal multiply of draw_q, then registered
  assign prod10 = {16'b0, draw_q} * {15'b0, Rcp10};
  assign prod21 = {16'b0, draw_q} * {15'b0, Rcp21};

  always_ff @(posedge clk_i) begin
    if (is_draw) draw_q <= draw;
    q10_q <= prod10[30:19];
    q21_q <= prod21[30:20];
  end

  // Remainders from the registered quotients
  assign rem10 = draw_q - ({q10_q, 3'b000} + {2'b00, q10_q, 1'b0});
  assign rem21 = draw_q - ({q21_q, 4'b0000} + {2'b00, q21_q, 2'b00} + {4'b0000, q21_q});

  // Derived values
  assign rd_len   = bc_q[CW-1] ? Full : bc_q;
  assign last_pos = len_q - 1'b1;
  assign last     = ((rp_q + 1'b1) == rd_len);
  assign run_len  = in_q.encrypt_mode ? len_q : len_q - CW'(2);
  assign run_err  = in_q.encrypt_mode ? (bc_q > Full - CW'(2))
                                      : ((bc_q > Full) || (bc_q < CW'(2)));
  assign off_val  = (mod_rem == idx_q) ? ((idx_q == '0) ? CW'(1) : '0) : mod_rem;
  assign xp_byte  = pkt_rd_q ^ xw_rd_q[7:0]
                  ^ ((idx_q >= CW'(1)) ? prev1_q[15:8] : 8'h00)
                  ^ {7'b0, (idx_q >= CW'(2)) & prev2_q[16]};
  assign sw_rule  = in_q.encrypt_mode ? psxc_pkg::rule_map(rule_rd_q) : rule_rd_q;
  assign sw_res   = psxc_pkg::swap_pair(sw_rule, pkt_rd_q, c_q);

  // Packet memory port control
  always_comb begin
    pkt_we = 1'b0;
    pkt_re = 1'b0;
    pkt_wa = idx_q[AW-1:0];
    pkt_ra = idx_q[AW-1:0];
    pkt_wd = 8'h00;
    case (cmd_i)
      psxc_pkg::C_LOAD: begin
        pkt_we = ~bc_q[CW-1];
        pkt_wa = bc_q[AW-1:0];
        pkt_wd = in_q.data_byte;
      end
      psxc_pkg::C_RD_ISSUE: begin
        pkt_re = 1'b1;
        pkt_ra = rp_q[AW-1:0];
      end
      psxc_pkg::C_SUM: pkt_re = (idx_q < bc_q);
      psxc_pkg::C_CK_LO: begin
        pkt_we = 1'b1;
        pkt_wa = bc_q[AW-1:0];
        pkt_wd = sum_q[7:0];
      end
      psxc_pkg::C_CK_HI: begin
        pkt_we = 1'b1;
        pkt_wa = AW'(bc_q + 1'b1);
        pkt_wd = sum_q[15:8];
      end
      psxc_pkg::C_XP_RD, psxc_pkg::C_SW_RD1: pkt_re = 1'b1;
      psxc_pkg::C_XP_WR: begin
        pkt_we = 1'b1;
        pkt_wd = xp_byte;
      end
      psxc_pkg::C_SW_RD2: begin
        pkt_re = 1'b1;
        pkt_ra = off_rd_q;
      end
      psxc_pkg::C_SW_WR0: begin
        pkt_we = 1'b1;
        pkt_wd = sw_res[15:8];
      end
      psxc_pkg::C_SW_WR1: begin
        pkt_we = 1'b1;
        pkt_wa = off_rd_q;
        pkt_wd = p_q;
      end
      psxc_pkg::C_CS_RD0: begin
        pkt_re = 1'b1;
        pkt_ra = AW'(len_q - CW'(2));
      end
      psxc_pkg::C_CS_RD1: begin
        pkt_re = 1'b1;
        pkt_ra = last_pos[AW-1:0];
      end
      default: ;
    endcase
  end

  // Memory ports
  always_ff @(posedge clk_i) begin
    if (pkt_we) pkt_mem[pkt_wa] <= pkt_wd;
    if (pkt_re) pkt_rd_q <= pkt_mem[pkt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == psxc_pkg::C_XW_C) xw_mem[idx_q[AW-1:0]] <= {1'b0, w_q} + {2'b00, draw};
    if (cmd_i == psxc_pkg::C_XP_RD) xw_rd_q <= xw_mem[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == psxc_pkg::C_OFF_W) off_mem[idx_q[AW-1:0]] <= off_val[AW-1:0];
    if (cmd_i == psxc_pkg::C_SW_RD0) off_rd_q <= off_mem[idx_q[AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i == psxc_pkg::C_RULE_W) rule_mem[idx_q[AW-1:0]] <= rem21[RW-1:0];
    if (cmd_i == psxc_pkg::C_SW_RD0) rule_rd_q <= rule_mem[idx_q[AW-1:0]];
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i)
      psxc_pkg::C_CAPTURE: in_q <= in_data_i;
      psxc_pkg::C_STK: begin
        if (idx_q[0]) stk2_q[idx_q[SW:1]] <= draw[7:0];
        else stk1_q[idx_q[SW:1]] <= draw[7:0];
      end
      psxc_pkg::C_XW_A: a_q <= stk2_q[rem10[SW-1:0]];
      psxc_pkg::C_XW_B: w_q <= a_q * stk1_q[rem10[SW-1:0]];
      psxc_pkg::C_XP_WR: begin
        prev1_q <= xw_rd_q;
        prev2_q <= prev1_q;
      end
      psxc_pkg::C_SW_RD2: c_q <= pkt_rd_q;
      psxc_pkg::C_SW_WR0: p_q <= sw_res[7:0];
      default: ;
    endcase
  end

  // Build the next output word
  always_comb begin
    out_d    = '0;
    out_load = 1'b0;
    case (cmd_i)
      psxc_pkg::C_RD_OUT: begin
        out_load = 1'b1;
        if (rp_q < rd_len) begin
          out_d.out_byte  = pkt_rd_q;
          out_d.last_byte = last;
        end else begin
          out_d.last_byte = 1'b1;
        end
      end
      psxc_pkg::C_ERR_OUT: begin
        out_load         = 1'b1;
        out_d.error_flag = 1'b1;
      end
      psxc_pkg::C_RUN_OUT: begin
        out_load             = 1'b1;
        out_d.packet_length  = run_len;
        out_d.seed_out       = sout_q;
        out_d.checksum_value = sum_q;
      end
      default: ;
    endcase
  end

  // Control registers and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q        <= '0;
      rp_q        <= '0;
      len_q       <= '0;
      idx_q       <= '0;
      gen_q       <= '0;
      sout_q      <= '0;
      sum_q       <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      // load a new word, or drop the held one once taken
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_q       <= out_d;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (is_draw) gen_q <= gen_nxt;
      case (cmd_i)
        psxc_pkg::C_LOAD: begin
          if (bc_q[CW-1]) bc_q <= Full + 1'b1;
          else bc_q <= bc_q + 1'b1;
        end
        psxc_pkg::C_RD_OUT: begin
          if (rp_q < rd_len) rp_q <= rp_q + 1'b1;
        end
        psxc_pkg::C_RUN_INIT: begin
          rp_q  <= '0;
          idx_q <= '0;
          sum_q <= '0;
          rdv_q <= 1'b0;
          if (!run_err) begin
            if (in_q.encrypt_mode) begin
              len_q  <= bc_q + CW'(2);
              gen_q  <= in_q.seed_word;
              sout_q <= {in_q.seed_word[23:16], in_q.seed_word[7:0],
                         in_q.seed_word[15:8], in_q.seed_word[31:24]};
            end else begin
              len_q  <= bc_q;
              gen_q  <= {in_q.seed_word[7:0], in_q.seed_word[31:24],
                         in_q.seed_word[15:8], in_q.seed_word[23:16]};
              sout_q <= {in_q.seed_word[7:0], in_q.seed_word[31:24],
                         in_q.seed_word[15:8], in_q.seed_word[23:16]};
            end
          end
        end
        psxc_pkg::C_ERR_OUT: bc_q <= '0;
        psxc_pkg::C_RUN_OUT: bc_q <= run_len;
        psxc_pkg::C_SUM: begin
          if (rdv_q) sum_q <= sum_q + {8'h00, ~pkt_rd_q};
          rdv_q <= (idx_q < bc_q);
          if (idx_q < bc_q) idx_q <= idx_q + 1'b1;
        end
        psxc_pkg::C_CK_HI: idx_q <= '0;
        psxc_pkg::C_STK: begin
          if (idx_q == CW'(2 * psxc_pkg::StackLen - 1)) idx_q <= '0;
          else idx_q <= idx_q + 1'b1;
        end
        psxc_pkg::C_XW_C, psxc_pkg::C_XP_WR: begin
          if (idx_q == last_pos) idx_q <= '0;
          else idx_q <= idx_q + 1'b1;
        end
        psxc_pkg::C_RULE_W: begin
          if (idx_q != last_pos) idx_q <= idx_q + 1'b1;
          else if (in_q.encrypt_mode) idx_q <= '0;
          else idx_q <= last_pos;
        end
        psxc_pkg::C_SW_WR1: begin
          if (in_q.encrypt_mode) begin
            idx_q <= (idx_q == last_pos) ? '0 : idx_q + 1'b1;
          end else begin
            idx_q <= (idx_q == '0) ? '0 : idx_q - 1'b1;
          end
        end
        psxc_pkg::C_CS_RD1: sum_q[7:0] <= pkt_rd_q;
        psxc_pkg::C_CS_RD2: sum_q[15:8] <= pkt_rd_q;
        default: ;
      endcase
    end
  end

  // Status toward the sequencer
  always_comb begin
    status_o.op        = psxc_pkg::op_e'(in_q.opcode);
    status_o.enc       = in_q.encrypt_mode;
    status_o.run_err   = run_err;
    status_o.stk_end   = (idx_q == CW'(2 * psxc_pkg::StackLen - 1));
    status_o.pos_end   = (idx_q == last_pos);
    status_o.swap_end  = in_q.encrypt_mode ? (idx_q == last_pos) : (idx_q == '0);
    status_o.scan_done = (idx_q == bc_q) && !rdv_q;
    status_o.mod_busy  = mod_busy;
    status_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
